FILE: rtl/mccs_pkg.sv
// Package: shared types and constants for the minimum-count change solver.
`timescale 1ns / 1ps
package mccs_pkg;

  localparam int unsigned MaxTarget  = 1023;
  localparam int unsigned MaxSectors = 32;
  localparam int unsigned ScoreW     = 10;
  localparam int unsigned CountW     = 11;
  localparam int unsigned AddrW      = $clog2(MaxTarget + 1);
  localparam int unsigned SecIdxW    = $clog2(MaxSectors);
  localparam int unsigned SecCntW    = $clog2(MaxSectors + 1);
  localparam int unsigned QDepth     = 2;

  localparam logic [CountW-1:0] CountInf = {CountW{1'b1}};

  // Queue entry between the front and back parts
  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic              last;
  } item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RELAX_RD,
    ST_RELAX_WR,
    ST_CHECK,
    ST_WALK_RD,
    ST_WALK_RD2,
    ST_WALK_DEC,
    ST_FLUSH,
    ST_EMIT
  } state_e;

endpackage

FILE: rtl/mccs_front.sv
// Front part: accept items and hold them in a short queue for the back part.
`timescale 1ns / 1ps
module mccs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mccs_pkg::ScoreW-1:0]   sector_score_i,
  input  logic                          last_sector_i,
  output logic                          q_valid_o,
  output mccs_pkg::item_t               q_item_o,
  input  logic                          q_pop_i
);
  import mccs_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  item_t             mem_q [QDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;
  logic              push;

  assign in_stall  = (cnt_q == (PtrW+1)'(QDepth));
  assign push      = in_valid && !in_stall;
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_q];

  // Store the transfer
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{score: sector_score_i, last: last_sector_i};
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (q_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
    end
  end

endmodule

FILE: rtl/mccs_back.sv
// Back part: relax the count table per sector, then walk back and emit parts.
`timescale 1ns / 1ps
module mccs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mccs_pkg::ScoreW-1:0]   target_i,
  input  logic                          q_valid_i,
  input  mccs_pkg::item_t               q_item_i,
  output logic                          q_pop_o,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mccs_pkg::ScoreW-1:0]   part_score_o,
  output logic [mccs_pkg::ScoreW-1:0]   part_count_o,
  output logic                          no_solution_o,
  output logic                          last_result_o
);
  import mccs_pkg::*;

  // Count table memory and sector store
  logic [CountW-1:0] tbl_mem [MaxTarget+1];
  logic [ScoreW-1:0] sec_mem [MaxSectors];

  state_e             state_q, state_d;
  logic [AddrW-1:0]   j_q, j_d;
  logic [ScoreW-1:0]  score_q, score_d;
  logic               last_q, last_d;
  logic [SecCntW-1:0] total_q, total_d;
  logic [SecCntW-1:0] idx_q, idx_d;
  logic [ScoreW-1:0]  remain_q, remain_d;
  logic [ScoreW-1:0]  taken_q, taken_d;
  logic [ScoreW-1:0]  p_q, p_d;
  logic [CountW-1:0]  rem_cnt_q, rem_cnt_d;
  logic [ScoreW-1:0]  o_score_q, o_score_d, o_count_q, o_count_d;
  logic               o_none_q, o_none_d, o_last_q, o_last_d, o_valid_q, o_valid_d;

  // Memory port controls
  logic               t_we;
  logic [AddrW-1:0]   t_waddr, t_raddr_a, t_raddr_b;
  logic [CountW-1:0]  t_wdata, t_rd_a_q, t_rd_b_q;
  logic               s_we;
  logic [SecIdxW-1:0] s_waddr, s_raddr;
  logic [ScoreW-1:0]  s_rd_q;

  // Port a returns the value being written to the same entry
  always_ff @(posedge clk_i) begin
    if (t_we) tbl_mem[t_waddr] <= t_wdata;
    t_rd_a_q <= (t_we && (t_waddr == t_raddr_a)) ? t_wdata : tbl_mem[t_raddr_a];
    t_rd_b_q <= tbl_mem[t_raddr_b];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) sec_mem[s_waddr] <= q_item_i.score;
    s_rd_q <= sec_mem[s_raddr];
  end

  assign out_valid     = o_valid_q;
  assign part_score_o  = o_score_q;
  assign part_count_o  = o_count_q;
  assign no_solution_o = o_none_q;
  assign last_result_o = o_last_q;

  logic [ScoreW:0] dif;
  logic            o_free, take;
  logic [CountW-1:0] cand;

  always_comb begin
    state_d = state_q; j_d = j_q; score_d = score_q; last_d = last_q;
    total_d = total_q; idx_d = idx_q; remain_d = remain_q; taken_d = taken_q;
    p_d = p_q; rem_cnt_d = rem_cnt_q;
    o_score_d = o_score_q; o_count_d = o_count_q; o_none_d = o_none_q;
    o_last_d = o_last_q; o_valid_d = o_valid_q;
    t_we = 1'b0; t_waddr = j_q; t_wdata = '0;
    t_raddr_a = j_q; t_raddr_b = j_q;
    s_we = 1'b0; s_waddr = total_q[SecIdxW-1:0]; s_raddr = '0;
    q_pop_o = 1'b0;
    dif = '0; cand = '0; take = 1'b0;
    o_free = !o_valid_q || !out_stall;
    if (o_valid_q && !out_stall) o_valid_d = 1'b0;

    unique case (state_q)
      // Sweep the table to its job start values
      ST_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = j_q;
        t_wdata = (j_q == '0) ? '0 : CountInf;
        j_d     = j_q + 1'b1;
        if (j_q == AddrW'(MaxTarget)) begin
          j_d = '0; total_d = '0; state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          last_d  = q_item_i.last;
          score_d = q_item_i.score;
          if (total_q < SecCntW'(MaxSectors)) begin
            s_we    = 1'b1;
            total_d = total_q + 1'b1;
            if (q_item_i.score != '0) begin
              j_d = AddrW'(q_item_i.score);
              state_d = ST_RELAX_RD;
            end else begin
              state_d = q_item_i.last ? ST_CHECK : ST_IDLE;
            end
          end else begin
            state_d = q_item_i.last ? ST_CHECK : ST_IDLE;
          end
          if (state_d == ST_CHECK) t_raddr_a = AddrW'(target_i);
        end
      end
      // Read table[j] and table[j-score]
      ST_RELAX_RD: begin
        t_raddr_a = j_q;
        t_raddr_b = j_q - AddrW'(score_q);
        state_d   = ST_RELAX_WR;
      end
      ST_RELAX_WR: begin
        cand = t_rd_b_q + 1'b1;
        if (t_rd_b_q != CountInf && cand < t_rd_a_q) begin
          t_we = 1'b1; t_waddr = j_q; t_wdata = cand;
        end
        if (j_q == AddrW'(MaxTarget)) begin
          if (last_q) begin
            state_d = ST_CHECK;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          j_d = j_q + 1'b1;
          state_d = ST_RELAX_RD;
        end
        t_raddr_a = AddrW'(target_i);
      end
      // Target reachable? Keep reading its entry while the output waits
      ST_CHECK: begin
        t_raddr_a = AddrW'(target_i);
        remain_d = target_i; taken_d = '0; idx_d = total_q;
        rem_cnt_d = t_rd_a_q;
        if (target_i == '0 || t_rd_a_q == CountInf) begin
          if (o_free) begin
            o_valid_d = 1'b1; o_score_d = '0; o_count_d = '0;
            o_none_d = 1'b1; o_last_d = 1'b1;
            j_d = '0; state_d = ST_CLEAR;
          end
        end else begin
          state_d = ST_WALK_RD;
        end
      end
      // Fetch sector idx-1
      ST_WALK_RD: begin
        if (remain_q == '0 || idx_q == '0) begin
          state_d = ST_FLUSH;
        end else begin
          s_raddr = SecIdxW'(idx_q - 1'b1);
          state_d = ST_WALK_RD2;
        end
      end
      // Fetch table[remain-p]
      ST_WALK_RD2: begin
        p_d = s_rd_q;
        t_raddr_b = AddrW'(remain_q - s_rd_q);
        state_d = ST_WALK_DEC;
      end
      ST_WALK_DEC: begin
        t_raddr_b = AddrW'(remain_q - p_q);
        dif  = {1'b0, remain_q} - {1'b0, p_q};
        take = (p_q != '0) && !dif[ScoreW] && (t_rd_b_q != CountInf) &&
               (rem_cnt_q == t_rd_b_q + 1'b1);
        if (take) begin
          taken_d = taken_q + 1'b1;
          remain_d = dif[ScoreW-1:0];
          rem_cnt_d = t_rd_b_q;
          t_raddr_b = AddrW'(dif[ScoreW-1:0] - p_q);
          if (dif[ScoreW-1:0] == '0) state_d = ST_FLUSH;
        end else if (taken_q != '0) begin
          if (o_free) begin
            o_valid_d = 1'b1; o_score_d = p_q; o_count_d = taken_q;
            o_none_d = 1'b0; o_last_d = 1'b0;
            taken_d = '0; idx_d = idx_q - 1'b1; state_d = ST_WALK_RD;
          end
        end else begin
          idx_d = idx_q - 1'b1; state_d = ST_WALK_RD;
        end
      end
      // Emit the pending part, or mark the end
      ST_FLUSH: begin
        if (o_free) begin
          o_valid_d = 1'b1; o_last_d = 1'b1;
          if (taken_q != '0 && idx_q != '0) begin
            o_score_d = p_q; o_count_d = taken_q; o_none_d = 1'b0;
          end else begin
            o_score_d = '0; o_count_d = '0; o_none_d = 1'b1;
          end
          j_d = '0; state_d = ST_CLEAR;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Advance the control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; j_q <= '0; total_q <= '0; o_valid_q <= 1'b0;
      last_q <= 1'b0; idx_q <= '0; taken_q <= '0;
    end else begin
      state_q <= state_d; j_q <= j_d; total_q <= total_d; o_valid_q <= o_valid_d;
      last_q <= last_d; idx_q <= idx_d; taken_q <= taken_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d; remain_q <= remain_d; p_q <= p_d; rem_cnt_q <= rem_cnt_d;
    o_score_q <= o_score_d; o_count_q <= o_count_d;
    o_none_q <= o_none_d; o_last_q <= o_last_d;
  end

endmodule

FILE: rtl/min_count_change_solver_top.sv
// Top level: minimum-count change solver with target register.
`timescale 1ns / 1ps
// Usage
//   Write target_score through cfg_we_i/cfg_wdata_i while the block is idle.
//   Sector scores enter on in_valid/in_stall, one transfer each, with
//   last_sector_i set on the final one. Results leave on out_valid/out_stall:
//   one transfer per sector used (part_score_o, part_count_o), the final one
//   with last_result_o; an unreachable or zero target gives one transfer with
//   no_solution_o set.
// Timing
//   A two-entry queue parts the input from the solver. Each non-zero sector
//   relaxes the count table one entry at a time from its score to 1023,
//   with a read state and a write state per entry on the single table memory.
//   The backward walk visits each sector in WALK_RD, WALK_RD2 and WALK_DEC
//   and stays in WALK_DEC for each further copy of a taken score. After a
//   run and after reset a clearing pass rewrites the whole table; no
//   sector is taken from the queue during it.
// Stalls
//   A stalled result holds on the output register; the walk waits for it.
module min_count_change_solver_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mccs_pkg::ScoreW-1:0] cfg_wdata_i,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mccs_pkg::ScoreW-1:0] sector_score_i,
  input  logic                        last_sector_i,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mccs_pkg::ScoreW-1:0] part_score_o,
  output logic [mccs_pkg::ScoreW-1:0] part_count_o,
  output logic                        no_solution_o,
  output logic                        last_result_o
);
  import mccs_pkg::*;

  logic [ScoreW-1:0] target_q;
  logic              q_valid, q_pop;
  item_t             q_item;

  // Hold the target register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) target_q <= '0;
    else if (cfg_we_i) target_q <= cfg_wdata_i;
  end

  mccs_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .sector_score_i, .last_sector_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  mccs_back u_back (
    .clk_i, .rst_ni, .target_i(target_q), .q_valid_i(q_valid), .q_item_i(q_item),
    .q_pop_o(q_pop), .out_valid, .out_stall, .part_score_o, .part_count_o,
    .no_solution_o, .last_result_o
  );

endmodule
